// ===== hdl/umc_pkg.sv =====
// ----------------------------------------------------------------------------
// umc_pkg
// Shared types and codes for the unitary matrix check unit.
// ----------------------------------------------------------------------------
package umc_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int QCOUNT_W   = 2;
  localparam int TOL_W      = 32;
  localparam int STATUS_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_QUBIT_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_SQ      = 1'd1;

  localparam logic [QCOUNT_W-1:0] QUBIT_COUNT_RST = 2'd1;
  localparam logic [TOL_W-1:0]    TOL_SQ_RST      = 32'd16;

  localparam logic [STATUS_W-1:0] STATUS_UNITARY     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_UNITARY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISMATCH    = 2'd2;

  // tags that travel with each product term
  typedef struct packed {
    logic vld;
    logic first;
    logic lastl;
    logic diag;
  } ctl_t;

endpackage

// ===== hdl/umc_ram.sv =====
// ----------------------------------------------------------------------------
// umc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module umc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/umc_datapath.sv =====
// ----------------------------------------------------------------------------
// umc_datapath
// Complex multiply-accumulate of row pairs, error rounding and saturation,
// squared magnitude and tolerance compare. Sticky fail flag per check.
// ----------------------------------------------------------------------------
module umc_datapath #(
  parameter int ENTRY_BITS = 16,
  parameter int MAX_QUBITS = 3
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clr_i,
  input  umc_pkg::ctl_t                ctl_i,
  input  logic [2*ENTRY_BITS-1:0]      a_i,
  input  logic [2*ENTRY_BITS-1:0]      b_i,
  input  logic [umc_pkg::TOL_W-1:0]    tol_sq_i,
  output logic                         busy_o,
  output logic                         fail_o
);

  localparam int E     = ENTRY_BITS;
  localparam int P_W   = 2 * E;
  localparam int T_W   = 2 * E + 1;
  localparam int ACC_W = 2 * E + MAX_QUBITS + 1;
  localparam int FRAC  = E - 2;
  localparam int SUM_W = (2 * E + 1 > umc_pkg::TOL_W) ? 2 * E + 1 : umc_pkg::TOL_W;

  localparam logic signed [ACC_W-1:0] HALF     = ACC_W'(1) << (FRAC - 1);
  localparam logic signed [ACC_W-1:0] ONE      = ACC_W'(1) << (2 * FRAC);
  localparam logic signed [ACC_W-1:0] HALF_DG  = HALF - ONE;
  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((64'sd1 <<< (E - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_LO   = -(ACC_W'(1) << (E - 1));

  logic signed [E-1:0] a_re, a_im, b_re, b_im;

  assign a_re = a_i[2*E-1:E];
  assign a_im = a_i[E-1:0];
  assign b_re = b_i[2*E-1:E];
  assign b_im = b_i[E-1:0];

  // stage 2: partial products
  umc_pkg::ctl_t         c2_r;
  logic signed [P_W-1:0] pac_r, pbd_r, pbc_r, pad_r;
  // stage 3: term sums
  umc_pkg::ctl_t         c3_r;
  logic signed [T_W-1:0] tre_r, tim_r;
  // stage 4: accumulate
  logic                    fin4_r, diag4_r;
  logic signed [ACC_W-1:0] acc_re_r, acc_im_r;
  // stage 5: rounded, saturated error
  logic                fin5_r;
  logic signed [E-1:0] r_re_r, r_im_r;
  // stage 6: squares
  logic                fin6_r;
  logic [P_W-1:0]      sq_re_r, sq_im_r;
  logic                fail_r;

  logic signed [ACC_W-1:0] acc_re_nxt, acc_im_nxt;
  logic signed [ACC_W-1:0] err_re, err_im, sh_re, sh_im, rnd_add;
  logic signed [E-1:0]     r_re_nxt, r_im_nxt;
  logic signed [P_W-1:0]   sq_re_nxt, sq_im_nxt;
  logic [SUM_W-1:0]        total;

  always_comb begin
    if (c3_r.first) begin
      acc_re_nxt = ACC_W'(tre_r);
      acc_im_nxt = ACC_W'(tim_r);
    end else begin
      acc_re_nxt = acc_re_r + ACC_W'(tre_r);
      acc_im_nxt = acc_im_r + ACC_W'(tim_r);
    end

    rnd_add = diag4_r ? HALF_DG : HALF;
    err_re  = acc_re_r + rnd_add;
    err_im  = acc_im_r + HALF;
    sh_re   = err_re >>> FRAC;
    sh_im   = err_im >>> FRAC;

    if (sh_re > SAT_HI) begin
      r_re_nxt = E'(SAT_HI);
    end else if (sh_re < SAT_LO) begin
      r_re_nxt = E'(SAT_LO);
    end else begin
      r_re_nxt = E'(sh_re);
    end
    if (sh_im > SAT_HI) begin
      r_im_nxt = E'(SAT_HI);
    end else if (sh_im < SAT_LO) begin
      r_im_nxt = E'(SAT_LO);
    end else begin
      r_im_nxt = E'(sh_im);
    end

    sq_re_nxt = P_W'(r_re_r) * P_W'(r_re_r);
    sq_im_nxt = P_W'(r_im_r) * P_W'(r_im_r);
    total     = SUM_W'(sq_re_r) + SUM_W'(sq_im_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r   <= '0;
      c3_r   <= '0;
      fin4_r <= 1'b0;
      fin5_r <= 1'b0;
      fin6_r <= 1'b0;
      fail_r <= 1'b0;
    end else begin
      c2_r   <= ctl_i;
      c3_r   <= c2_r;
      fin4_r <= c3_r.vld & c3_r.lastl;
      fin5_r <= fin4_r;
      fin6_r <= fin5_r;
      if (clr_i) begin
        fail_r <= 1'b0;
      end else if (fin6_r && (total > SUM_W'(tol_sq_i))) begin
        fail_r <= 1'b1;
      end
    end
    pac_r    <= P_W'(a_re) * P_W'(b_re);
    pbd_r    <= P_W'(a_im) * P_W'(b_im);
    pbc_r    <= P_W'(a_im) * P_W'(b_re);
    pad_r    <= P_W'(a_re) * P_W'(b_im);
    tre_r    <= T_W'(pac_r) + T_W'(pbd_r);
    tim_r    <= T_W'(pbc_r) - T_W'(pad_r);
    if (c3_r.vld) begin
      acc_re_r <= acc_re_nxt;
      acc_im_r <= acc_im_nxt;
    end
    diag4_r  <= c3_r.diag;
    r_re_r   <= r_re_nxt;
    r_im_r   <= r_im_nxt;
    sq_re_r  <= P_W'(sq_re_nxt);
    sq_im_r  <= P_W'(sq_im_nxt);
  end

  assign busy_o = c2_r.vld | c3_r.vld | fin4_r | fin5_r | fin6_r;
  assign fail_o = fail_r;

endmodule

// ===== hdl/unitary_matrix_check_unit.sv =====
// ----------------------------------------------------------------------------
// unitary_matrix_check_unit
// Loads a complex 2^k x 2^k matrix row-major and reports whether M * M^H
// matches the identity within a squared-error tolerance.
//
//   port group | dir | handshake          | word
//   cfg_       | in  | cfg_we             | cfg_index, cfg_data
//   in_        | in  | in_valid, in_stall | in_entry_re, in_entry_im, in_last
//   out_       | out | out_valid,out_stall| out_status
//
// Loading accepts one word per cycle while in_stall is low. After a last word
// with a correct count, the check streams dim^3 row-pair reads from two copies
// of the matrix RAM, one multiply-accumulate per cycle, then drains the
// pipeline; in_stall is high throughout the check and the drain.
// Status words go to an output register; a last word stalls while it is full.
// Reset is synchronous, active low; matrix RAM contents are not cleared.
// ----------------------------------------------------------------------------
module unitary_matrix_check_unit #(
  parameter int MAX_QUBITS = 3,
  parameter int ENTRY_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [umc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [umc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [ENTRY_BITS-1:0]     in_entry_re,
  input  logic signed [ENTRY_BITS-1:0]     in_entry_im,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [umc_pkg::STATUS_W-1:0]     out_status
);

  localparam int KW    = MAX_QUBITS;
  localparam int AW    = 2 * MAX_QUBITS;
  localparam int CNT_W = 2 * MAX_QUBITS + 1;
  localparam int DW    = 2 * ENTRY_BITS;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CHECK,
    ST_DRAIN
  } state_t;

  state_t                          state_r, state_nxt;
  logic [umc_pkg::QCOUNT_W-1:0]    qubit_count_r, qubit_count_nxt;
  logic [umc_pkg::TOL_W-1:0]       tol_sq_r, tol_sq_nxt;
  logic [CNT_W-1:0]                load_count_r, load_count_nxt;
  logic                            overflow_r, overflow_nxt;
  logic [umc_pkg::QCOUNT_W-1:0]    k_r, k_nxt;
  logic [KW-1:0]                   lim_r, lim_nxt;
  logic [KW-1:0]                   i_r, i_nxt, j_r, j_nxt, l_r, l_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [umc_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;
  umc_pkg::ctl_t                   c1_r, c0;

  logic [umc_pkg::QCOUNT_W-1:0]    k_eff;
  logic [CNT_W-1:0]                total, cnt_after;
  logic                            in_acc, store_en, ovf_after, mismatch, start;
  logic [AW-1:0]                   addr_a, addr_b;
  logic [DW-1:0]                   rd_a, rd_b;
  logic                            dp_busy, dp_fail;

  assign k_eff    = (int'(qubit_count_r) > MAX_QUBITS) ?
                    umc_pkg::QCOUNT_W'(MAX_QUBITS) : qubit_count_r;
  assign total    = CNT_W'(1) << {k_eff, 1'b0};
  assign in_stall = (state_r != ST_LOAD) || (out_valid_r && in_last);
  assign in_acc   = in_valid && !in_stall;
  assign store_en = in_acc && (load_count_r < total);

  assign cnt_after = store_en ? load_count_r + CNT_W'(1) : load_count_r;
  assign ovf_after = overflow_r | (in_acc & ~store_en);
  assign mismatch  = ovf_after || (cnt_after != total);
  assign start     = in_acc && in_last && !mismatch;

  assign addr_a = (AW'(i_r) << k_r) | AW'(l_r);
  assign addr_b = (AW'(j_r) << k_r) | AW'(l_r);

  always_comb begin
    state_nxt       = state_r;
    qubit_count_nxt = qubit_count_r;
    tol_sq_nxt      = tol_sq_r;
    load_count_nxt  = load_count_r;
    overflow_nxt    = overflow_r;
    k_nxt           = k_r;
    lim_nxt         = lim_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    l_nxt           = l_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    c0              = '0;

    if (cfg_we) begin
      case (cfg_index)
        umc_pkg::CFG_QUBIT_COUNT: qubit_count_nxt = cfg_data[umc_pkg::QCOUNT_W-1:0];
        umc_pkg::CFG_TOL_SQ:      tol_sq_nxt      = cfg_data[umc_pkg::TOL_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          load_count_nxt = cnt_after;
          overflow_nxt   = ovf_after;
          if (in_last) begin
            load_count_nxt = '0;
            overflow_nxt   = 1'b0;
            if (mismatch) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = umc_pkg::STATUS_MISMATCH;
            end else begin
              state_nxt = ST_CHECK;
              k_nxt     = k_eff;
              lim_nxt   = KW'((1 << k_eff) - 1);
              i_nxt     = '0;
              j_nxt     = '0;
              l_nxt     = '0;
            end
          end
        end
      end
      ST_CHECK: begin
        c0.vld   = 1'b1;
        c0.first = (l_r == '0);
        c0.lastl = (l_r == lim_r);
        c0.diag  = (i_r == j_r);
        if (l_r != lim_r) begin
          l_nxt = l_r + KW'(1);
        end else begin
          l_nxt = '0;
          if (j_r != lim_r) begin
            j_nxt = j_r + KW'(1);
          end else begin
            j_nxt = '0;
            if (i_r != lim_r) begin
              i_nxt = i_r + KW'(1);
            end else begin
              state_nxt = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!c1_r.vld && !dp_busy) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = dp_fail ? umc_pkg::STATUS_NOT_UNITARY
                                   : umc_pkg::STATUS_UNITARY;
          state_nxt      = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_LOAD;
      qubit_count_r <= umc_pkg::QUBIT_COUNT_RST;
      tol_sq_r      <= umc_pkg::TOL_SQ_RST;
      load_count_r  <= '0;
      overflow_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      c1_r          <= '0;
    end else begin
      state_r       <= state_nxt;
      qubit_count_r <= qubit_count_nxt;
      tol_sq_r      <= tol_sq_nxt;
      load_count_r  <= load_count_nxt;
      overflow_r    <= overflow_nxt;
      out_valid_r   <= out_valid_nxt;
      c1_r          <= c0;
    end
    k_r          <= k_nxt;
    lim_r        <= lim_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    l_r          <= l_nxt;
    out_status_r <= out_status_nxt;
  end

  // two copies of the matrix: one read at row i, one at row j
  umc_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_ram_a (
    .clk   (clk),
    .we    (store_en),
    .waddr (load_count_r[AW-1:0]),
    .wdata ({in_entry_re, in_entry_im}),
    .raddr (addr_a),
    .rdata (rd_a)
  );

  umc_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_ram_b (
    .clk   (clk),
    .we    (store_en),
    .waddr (load_count_r[AW-1:0]),
    .wdata ({in_entry_re, in_entry_im}),
    .raddr (addr_b),
    .rdata (rd_b)
  );

  umc_datapath #(.ENTRY_BITS(ENTRY_BITS), .MAX_QUBITS(MAX_QUBITS)) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_i    (start),
    .ctl_i    (c1_r),
    .a_i      (rd_a),
    .b_i      (rd_b),
    .tol_sq_i (tol_sq_r),
    .busy_o   (dp_busy),
    .fail_o   (dp_fail)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule
